@@ rtl/core/mhpq_pkg.sv @@
// Package for the binary max-heap priority queue: payload types, codes, states.
// No dependencies.
`default_nettype none
package mhpq_pkg;

  localparam int unsigned DefaultCapacity = 128;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_e;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] max_value;
    logic        [7:0]  count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,    // read parent of pos
    S_UP_CMP,   // compare parent with carried value
    S_DN_RDL,   // read left child
    S_DN_RDR,   // read right child, left data arrives
    S_DN_CMP,   // right data arrives, pick
    S_SCAN_RD,  // issue scan read
    S_SCAN_CMP, // compare scan data
    S_LAST_RD,  // read last entry
    S_LAST_WAIT,
    S_ROOT_WAIT,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

@@ rtl/core/max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue.
// Depends on mhpq_pkg and mhpq_ram.
`default_nettype none
// Max-heap of signed 32-bit values held in one RAM of CAPACITY words with a
// registered read. One request beat (insert, extract-max, delete by value)
// yields one response beat with status, extracted maximum and count.
// Requests are handled one at a time; the sift loops go through the single
// RAM read port. The sifted value is carried in a register (hole method).
// Insert sifts up, reading the parent and comparing at each level; extract
// reads the root and the last entry, then sifts down, reading the left and
// right child and picking at each level; delete adds a linear scan ahead of
// the match. A finished response sits in an output register; the block does
// not need a clearing pass, as only entries below the count are ever used.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::DefaultCapacity
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output      logic           req_ready_o,
  input  wire mhpq_pkg::req_t req_i,
  output      logic           rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output      mhpq_pkg::rsp_t rsp_o
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  mhpq_pkg::state_e state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;        // entries held
  logic [CW-1:0]      pos_q, pos_d;        // hole position
  logic signed [31:0] val_q, val_d;        // value being sifted
  logic signed [31:0] key_q, key_d;        // value searched on delete
  logic signed [31:0] lval_q, lval_d;      // left child data
  logic               del_q, del_d;        // delete: sift up after down
  logic               moved_q, moved_d;    // sift down moved the hole
  mhpq_pkg::rsp_t     res_q, res_d;        // response being built
  mhpq_pkg::rsp_t     rsp_q, rsp_d;        // response on the output
  logic               rv_q, rv_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic signed [31:0] rd_s;

  mhpq_ram #(.Width(32), .Depth(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );
  assign rd_s = $signed(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    val_q   <= val_d;
    key_q   <= key_d;
    lval_q  <= lval_d;
    del_q   <= del_d;
    moved_q <= moved_d;
    res_q   <= res_d;
    rsp_q   <= rsp_d;
  end

  assign req_ready_o = (state_q == mhpq_pkg::S_IDLE);
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  logic [CW:0]   lidx, ridx, par;
  logic [CW-1:0] cnt_m1;

  always_comb begin
    lidx   = {pos_q, 1'b1};
    ridx   = {pos_q, 1'b0} + (CW+1)'(2);
    par    = {1'b0, (pos_q - CW'(1)) >> 1};
    cnt_m1 = cnt_q - CW'(1);

    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    val_d   = val_q;
    key_d   = key_q;
    lval_d  = lval_q;
    del_d   = del_q;
    moved_d = moved_q;
    res_d   = res_q;
    rsp_d   = rsp_q;
    rv_d    = rv_q;
    we      = 1'b0;
    waddr   = pos_q[AW-1:0];
    wdata   = val_q;
    raddr   = '0;

    if (rv_q && rsp_ready_i) begin
      rv_d = 1'b0;
    end

    unique case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (req_valid_i) begin
          res_d.status    = mhpq_pkg::ST_OK;
          res_d.max_value = '0;
          val_d = req_i.value;
          key_d = req_i.value;
          del_d = 1'b0;
          unique case (mhpq_pkg::kind_e'(req_i.kind))
            mhpq_pkg::KIND_INSERT: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                res_d.status = mhpq_pkg::ST_OVERFLOW;
                state_d = mhpq_pkg::S_DONE;
              end else begin
                pos_d = cnt_q;
                cnt_d = cnt_q + CW'(1);
                state_d = mhpq_pkg::S_UP_RD;
              end
            end
            mhpq_pkg::KIND_EXTRACT: begin
              if (cnt_q == '0) begin
                res_d.status    = mhpq_pkg::ST_UNDERFLOW;
                res_d.max_value = -32'sd1;
                state_d = mhpq_pkg::S_DONE;
              end else begin
                raddr   = '0;
                state_d = mhpq_pkg::S_ROOT_WAIT;
              end
            end
            mhpq_pkg::KIND_DELETE: begin
              pos_d   = '0;
              del_d   = 1'b1;
              state_d = mhpq_pkg::S_SCAN_RD;
            end
            default: state_d = mhpq_pkg::S_DONE;
          endcase
        end
      end
      mhpq_pkg::S_ROOT_WAIT: begin
        res_d.max_value = rd_s;
        cnt_d   = cnt_m1;
        pos_d   = '0;
        raddr   = cnt_m1[AW-1:0];
        state_d = mhpq_pkg::S_LAST_WAIT;
      end
      mhpq_pkg::S_SCAN_RD: begin
        if (pos_q >= cnt_q) begin
          res_d.status = mhpq_pkg::ST_NOTFOUND;
          state_d = mhpq_pkg::S_DONE;
        end else begin
          raddr   = pos_q[AW-1:0];
          state_d = mhpq_pkg::S_SCAN_CMP;
        end
      end
      mhpq_pkg::S_SCAN_CMP: begin
        if (rd_s == key_q) begin
          cnt_d = cnt_m1;
          if (pos_q < cnt_m1) begin
            state_d = mhpq_pkg::S_LAST_RD;
          end else begin
            state_d = mhpq_pkg::S_DONE;
          end
        end else begin
          pos_d   = pos_q + CW'(1);
          state_d = mhpq_pkg::S_SCAN_RD;
        end
      end
      mhpq_pkg::S_LAST_RD: begin
        raddr   = cnt_q[AW-1:0];
        state_d = mhpq_pkg::S_LAST_WAIT;
      end
      mhpq_pkg::S_LAST_WAIT: begin
        val_d   = rd_s;
        moved_d = 1'b0;
        state_d = mhpq_pkg::S_DN_RDL;
      end
      mhpq_pkg::S_DN_RDL: begin
        if (lidx >= {1'b0, cnt_q}) begin
          // hole is a leaf: settle, then maybe sift up on delete
          we = 1'b1;
          if (del_q && !moved_q) begin
            state_d = mhpq_pkg::S_UP_RD;
          end else begin
            state_d = mhpq_pkg::S_DONE;
          end
        end else begin
          raddr   = lidx[AW-1:0];
          state_d = mhpq_pkg::S_DN_RDR;
        end
      end
      mhpq_pkg::S_DN_RDR: begin
        lval_d = rd_s;
        raddr  = ridx[AW-1:0];
        state_d = mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        if ((ridx < {1'b0, cnt_q} && rd_s > val_q) || lval_q > val_q) begin
          // child moves up into hole
          we    = 1'b1;
          wdata = (ridx < {1'b0, cnt_q} && rd_s > lval_q) ? rd_s : lval_q;
          pos_d = (ridx < {1'b0, cnt_q} && rd_s > lval_q) ? ridx[CW-1:0]
                                                             : lidx[CW-1:0];
          moved_d = 1'b1;
          state_d = mhpq_pkg::S_DN_RDL;
        end else begin
          we = 1'b1;
          if (del_q && !moved_q) begin
            state_d = mhpq_pkg::S_UP_RD;
          end else begin
            state_d = mhpq_pkg::S_DONE;
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = mhpq_pkg::S_DONE;
        end else begin
          raddr   = par[AW-1:0];
          state_d = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        if (rd_s < val_q) begin
          we      = 1'b1;
          wdata   = rd_s;
          pos_d   = par[CW-1:0];
          state_d = mhpq_pkg::S_UP_RD;
        end else begin
          we      = 1'b1;
          state_d = mhpq_pkg::S_DONE;
        end
      end
      mhpq_pkg::S_DONE: begin
        // output register is loaded only once the previous beat has left
        if (!rv_q || rsp_ready_i) begin
          rv_d        = 1'b1;
          rsp_d       = res_q;
          rsp_d.count = 8'(cnt_q);
          state_d     = mhpq_pkg::S_IDLE;
        end
      end
      default: state_d = mhpq_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/core/mhpq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mhpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ dv/max_heap_priority_queue_test.sv @@
// Testbench for max_heap_priority_queue: random and directed insert, extract and delete
// beats checked against an in-bench heap predictor with random stalls on both sides.
// Depends on mhpq_pkg and the RTL of the block.
`default_nettype none
module max_heap_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = mhpq_pkg::DefaultCapacity;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  mhpq_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  mhpq_pkg::rsp_t rsp_o;

  always #2 clk_i = ~clk_i;

  max_heap_priority_queue dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  // Predictor state: shadow heap and its fill.
  logic signed [31:0] shadow_heap [Cap];
  int unsigned shadow_count = 0;
  mhpq_pkg::rsp_t pending_rsp [$];
  int unsigned mismatches = 0;
  bit rsp_stalls_on = 1'b1;
  int unsigned idle_cycles = 0;

  function automatic void heap_swap(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void heap_rise(int unsigned pos);
    int unsigned up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(shadow_heap[up] < shadow_heap[pos])) break;
      heap_swap(up, pos);
      pos = up;
    end
  endfunction

  function automatic void heap_sink(int unsigned pos);
    int unsigned best, l, r;
    while (pos < shadow_count) begin
      best = pos;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      if (l < shadow_count && shadow_heap[l] > shadow_heap[best]) best = l;
      if (r < shadow_count && shadow_heap[r] > shadow_heap[best]) best = r;
      if (best == pos) break;
      heap_swap(pos, best);
      pos = best;
    end
  endfunction

  // Apply one request to the shadow heap and return the expected response.
  function automatic mhpq_pkg::rsp_t heap_apply(mhpq_pkg::req_t rq);
    mhpq_pkg::rsp_t rs;
    int unsigned i;
    bit hit;
    rs = '0;
    rs.status = mhpq_pkg::ST_OK;
    case (mhpq_pkg::kind_e'(rq.kind))
      mhpq_pkg::KIND_INSERT: begin
        if (shadow_count >= Cap) rs.status = mhpq_pkg::ST_OVERFLOW;
        else begin
          shadow_heap[shadow_count] = rq.value;
          heap_rise(shadow_count);
          shadow_count++;
        end
      end
      mhpq_pkg::KIND_EXTRACT: begin
        if (shadow_count == 0) begin
          rs.status = mhpq_pkg::ST_UNDERFLOW;
          rs.max_value = -32'sd1;
        end else begin
          rs.max_value = shadow_heap[0];
          shadow_count--;
          shadow_heap[0] = shadow_heap[shadow_count];
          heap_sink(0);
        end
      end
      mhpq_pkg::KIND_DELETE: begin
        hit = 1'b0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_heap[i] == rq.value) begin
            hit = 1'b1;
            break;
          end
        end
        if (!hit) rs.status = mhpq_pkg::ST_NOTFOUND;
        else begin
          shadow_count--;
          if (i < shadow_count) begin
            shadow_heap[i] = shadow_heap[shadow_count];
            heap_sink(i);
            heap_rise(i);
          end
        end
      end
      default: ;
    endcase
    rs.count = shadow_count[7:0];
    return rs;
  endfunction

  // Send one request beat, with an optional random gap in front.
  // Valid stays high after the beat; a gap in the next call or drain_rsp drops it.
  task automatic send_req(mhpq_pkg::kind_e k, logic signed [31:0] v, bit gaps = 1'b1);
    if (gaps && $urandom_range(3) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= '{kind: k, value: v};
    do @(posedge clk_i); while (!req_ready_o);
    pending_rsp.push_back(heap_apply('{kind: k, value: v}));
  endtask

  task automatic drain_rsp();
    req_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Pick a random value, often one already held so deletes hit.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(2) == 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      2: return (shadow_count != 0) ? shadow_heap[$urandom_range(shadow_count - 1)] : 0;
      default: return $signed($urandom_range(40)) - 20;
    endcase
  endfunction

  // Response side: random stall bursts, compare each beat with the oldest expectation.
  initial begin
    forever begin
      if (rsp_stalls_on && $urandom_range(4) == 0) begin
        rsp_ready_i <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk_i);
      end
      rsp_ready_i <= 1'b1;
      @(posedge clk_i);
      if (rsp_valid_o && rsp_ready_i) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response beat %p", rsp_o);
        end else begin
          mhpq_pkg::rsp_t want;
          want = pending_rsp.pop_front();
          if (rsp_o.status !== want.status || rsp_o.max_value !== want.max_value ||
              rsp_o.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected st=%0d max=%0d cnt=%0d got st=%0d max=%0d cnt=%0d",
                       want.status, want.max_value, want.count,
                       rsp_o.status, rsp_o.max_value, rsp_o.count);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_empty_and_odd_kind();
    send_req(mhpq_pkg::KIND_EXTRACT, 0);
    send_req(mhpq_pkg::KIND_DELETE, 5);
    send_req(mhpq_pkg::KIND_NONE, 32'sh7FFF_FFFF);
    send_req(mhpq_pkg::KIND_NONE, 32'sh8000_0000);
  endtask

  task automatic test_extremes_and_ties();
    send_req(mhpq_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
    send_req(mhpq_pkg::KIND_INSERT, 32'sh8000_0000);
    send_req(mhpq_pkg::KIND_INSERT, 7);
    send_req(mhpq_pkg::KIND_INSERT, 7);
    send_req(mhpq_pkg::KIND_INSERT, 7);
    send_req(mhpq_pkg::KIND_INSERT, -1);
    send_req(mhpq_pkg::KIND_DELETE, -1);             // last slot, no sift
    send_req(mhpq_pkg::KIND_DELETE, 32'sh7FFF_FFFF); // root delete
    send_req(mhpq_pkg::KIND_DELETE, 1234);           // not found
    send_req(mhpq_pkg::KIND_NONE, 3);
    repeat (5) send_req(mhpq_pkg::KIND_EXTRACT, 0);
    drain_rsp();
  endtask

  // Fill to capacity, overflow, then drain past empty.
  task automatic test_full_heap();
    repeat (Cap) send_req(mhpq_pkg::KIND_INSERT, pick_value());
    send_req(mhpq_pkg::KIND_INSERT, 1);
    send_req(mhpq_pkg::KIND_DELETE, shadow_heap[Cap - 1]);
    send_req(mhpq_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
    send_req(mhpq_pkg::KIND_INSERT, 2);
    repeat (Cap + 1) send_req(mhpq_pkg::KIND_EXTRACT, 0);
    drain_rsp();
  endtask

  // Mixed traffic biased to hold the heap partly full.
  task automatic test_random_mix(int unsigned n, bit gaps);
    int unsigned r;
    for (int unsigned j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 45) send_req(mhpq_pkg::KIND_INSERT, pick_value(), gaps);
      else if (r < 72) send_req(mhpq_pkg::KIND_EXTRACT, $urandom, gaps);
      else if (r < 97) send_req(mhpq_pkg::KIND_DELETE, pick_value(), gaps);
      else send_req(mhpq_pkg::KIND_NONE, $urandom, gaps);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_odd_kind();
    test_extremes_and_ties();
    test_full_heap();
    test_random_mix(600, 1'b1);
    drain_rsp(); // sender holds off until every response is back
    test_random_mix(300, 1'b1);
    rsp_stalls_on = 1'b0;
    test_random_mix(150, 1'b0);
    drain_rsp();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
